// ===== rtl/sirf_pkg.sv =====
package sirf_pkg;

  localparam int KindW = 2;
  localparam int RowW  = 3;
  localparam int ColW  = 3;
  localparam int PixW  = 8;
  localparam int OpW   = 2;

  typedef logic [KindW-1:0] kind_t;
  typedef logic [RowW-1:0]  row_t;
  typedef logic [ColW-1:0]  col_t;
  typedef logic [PixW-1:0]  pix_t;
  typedef logic [OpW-1:0]   op_t;

  localparam kind_t KIND_WRITE = 2'd0;
  localparam kind_t KIND_READ  = 2'd1;
  localparam kind_t KIND_XFORM = 2'd2;

  localparam op_t OP_ROT_CW    = 2'd0;
  localparam op_t OP_ROT_CCW   = 2'd1;
  localparam op_t OP_MIRROR_TB = 2'd2;
  localparam op_t OP_MIRROR_LR = 2'd3;

  // control from the main sequencer to the pair walker
  typedef struct packed {
    logic start;
    logic step;
    op_t  op;
  } walk_ctrl_t;

endpackage

// ===== rtl/sirf_in_if.sv =====
interface sirf_in_if;
  import sirf_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  row_t  row;
  col_t  col;
  pix_t  pixel_in;
  op_t   transform_op;

  modport source (output valid, output kind, output row, output col, output pixel_in,
                  output transform_op, input ready);
  modport sink   (input valid, input kind, input row, input col, input pixel_in,
                  input transform_op, output ready);
endinterface

// ===== rtl/sirf_out_if.sv =====
interface sirf_out_if;
  import sirf_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

// ===== rtl/sirf_store.sv =====
module sirf_store #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  sirf_pkg::pix_t       wdata_i,
  input  logic [AddrW-1:0]     raddr_a_i,
  input  logic [AddrW-1:0]     raddr_b_i,
  output sirf_pkg::pix_t       rdata_a_o,
  output sirf_pkg::pix_t       rdata_b_o
);
  import sirf_pkg::*;

  pix_t mem [Depth];
  pix_t rdata_a_q;
  pix_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/sirf_walk.sv =====
module sirf_walk #(
  parameter int Size  = 8,
  parameter int AddrW = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sirf_pkg::walk_ctrl_t   ctrl_i,
  output logic [AddrW-1:0]       addr_a_o,
  output logic [AddrW-1:0]       addr_b_o,
  output logic                   last_o
);
  import sirf_pkg::*;

  localparam int IdxW = $clog2(Size);
  localparam int Half = Size / 2;

  localparam logic [1:0] PH_TR = 2'd0;
  localparam logic [1:0] PH_LR = 2'd1;
  localparam logic [1:0] PH_TB = 2'd2;

  logic [1:0]      phase_q, phase_d;
  logic [1:0]      phase2_q, phase2_d;
  logic            two_q, two_d;
  logic [IdxW-1:0] r_q, r_d;
  logic [IdxW-1:0] c_q, c_d;

  logic            pass_end;
  logic [IdxW-1:0] r_nx, c_nx;

  always_comb begin
    pass_end = 1'b0;
    r_nx     = r_q;
    c_nx     = c_q + 1'b1;
    case (phase_q)
      PH_TR: begin
        pass_end = (r_q == IdxW'(Size - 2)) && (c_q == IdxW'(Size - 1));
        if (c_q == IdxW'(Size - 1)) begin
          r_nx = r_q + 1'b1;
          c_nx = IdxW'(r_q + 2'd2);
        end
      end
      PH_LR: begin
        pass_end = (r_q == IdxW'(Size - 1)) && (c_q == IdxW'(Half - 1));
        if (c_q == IdxW'(Half - 1)) begin
          r_nx = r_q + 1'b1;
          c_nx = '0;
        end
      end
      default: begin
        pass_end = (r_q == IdxW'(Half - 1)) && (c_q == IdxW'(Size - 1));
        if (c_q == IdxW'(Size - 1)) begin
          r_nx = r_q + 1'b1;
          c_nx = '0;
        end
      end
    endcase
  end

  assign last_o = pass_end && !two_q;

  always_comb begin
    phase_d  = phase_q;
    phase2_d = phase2_q;
    two_d    = two_q;
    r_d      = r_q;
    c_d      = c_q;
    if (ctrl_i.start) begin
      r_d = '0;
      case (ctrl_i.op)
        OP_ROT_CW: begin
          phase_d  = PH_TR;
          phase2_d = PH_LR;
          two_d    = 1'b1;
        end
        OP_ROT_CCW: begin
          phase_d  = PH_LR;
          phase2_d = PH_TR;
          two_d    = 1'b1;
        end
        OP_MIRROR_TB: begin
          phase_d = PH_TB;
          two_d   = 1'b0;
        end
        default: begin
          phase_d = PH_LR;
          two_d   = 1'b0;
        end
      endcase
      c_d = (phase_d == PH_TR) ? IdxW'(1) : '0;
    end else if (ctrl_i.step) begin
      if (pass_end) begin
        // move on to the second pass of a rotation
        phase_d = phase2_q;
        two_d   = 1'b0;
        r_d     = '0;
        c_d     = (phase2_q == PH_TR) ? IdxW'(1) : '0;
      end else begin
        r_d = r_nx;
        c_d = c_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TR;
      phase2_q <= PH_TR;
      two_q    <= 1'b0;
      r_q      <= '0;
      c_q      <= '0;
    end else begin
      phase_q  <= phase_d;
      phase2_q <= phase2_d;
      two_q    <= two_d;
      r_q      <= r_d;
      c_q      <= c_d;
    end
  end

  always_comb begin
    addr_a_o = AddrW'(int'(r_q) * Size + int'(c_q));
    case (phase_q)
      PH_TR:   addr_b_o = AddrW'(int'(c_q) * Size + int'(r_q));
      PH_LR:   addr_b_o = AddrW'(int'(r_q) * Size + (Size - 1 - int'(c_q)));
      default: addr_b_o = AddrW'((Size - 1 - int'(r_q)) * Size + int'(c_q));
    endcase
  end

  // a pair is never swapped with itself
  a_pair_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step |-> (addr_a_o != addr_b_o))
    else $error("walker produced a pair with equal addresses");

  a_second_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.step && pass_end && two_q && !ctrl_i.start) |=> (!two_q && r_q == '0))
    else $error("second pass did not restart at the first row");

  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> !two_q)
    else $error("last pair flagged while a pass is still pending");

endmodule

// ===== rtl/square_image_rotate_flip.sv =====
// Square pixel store with in-place rotate and mirror.
//
// Input channel in_i carries one beat per command: kind selects a pixel
// write, a pixel read or a whole-image transform (transform_op picks rotate
// clockwise, rotate counter-clockwise, mirror top-bottom or mirror
// left-right). Only reads give a beat on out_o, carrying pixel_out; a read
// outside the square returns zero, a write outside it is dropped.
// A read gives a registered result. A transform swaps pixel pairs through
// one store with two read ports and one write port, each pair in the states
// ST_X_RD, ST_X_WA and ST_X_WB: a mirror swaps Size*(Size/2) pairs and a
// rotation adds Size*(Size-1)/2 pairs for the transpose.
// After reset the store is swept to zero, one entry a cycle, and in_i.ready
// stays low until the sweep ends.
// A result waits in the output register while out_o is stalled; writes and
// transforms keep being taken, and a further read is taken but waits, with
// in_i.ready low, until the pending result has left.
module square_image_rotate_flip #(
  parameter int Size = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sirf_in_if.sink     in_i,
  sirf_out_if.source  out_o
);
  import sirf_pkg::*;

  localparam int Depth = Size * Size;
  localparam int AddrW = $clog2(Depth);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_RD_WAIT = 3'd2;
  localparam logic [2:0] ST_X_RD    = 3'd3;
  localparam logic [2:0] ST_X_WA    = 3'd4;
  localparam logic [2:0] ST_X_WB    = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             zero_q, zero_d;
  pix_t             tmp_q, tmp_d;
  pix_t             pixel_q, pixel_d;
  logic             out_valid_q, out_valid_d;

  logic             accept;
  logic             in_square;
  logic [AddrW-1:0] in_addr;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  pix_t             mem_wdata;
  logic [AddrW-1:0] raddr_a;
  pix_t             rdata_a, rdata_b;

  walk_ctrl_t       walk_ctrl;
  logic [AddrW-1:0] walk_addr_a, walk_addr_b;
  logic             walk_last;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign in_square  = (int'(in_i.row) < Size) && (int'(in_i.col) < Size);
  assign in_addr    = AddrW'(int'(in_i.row) * Size + int'(in_i.col));

  assign out_o.valid     = out_valid_q;
  assign out_o.pixel_out = pixel_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    addr_d      = addr_q;
    zero_d      = zero_q;
    tmp_d       = tmp_q;
    pixel_d     = pixel_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mem_we      = 1'b0;
    mem_waddr   = walk_addr_a;
    mem_wdata   = rdata_b;
    raddr_a     = walk_addr_a;
    walk_ctrl   = '{start: 1'b0, step: 1'b0, op: in_i.transform_op};

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        raddr_a = in_addr;
        if (accept) begin
          case (in_i.kind)
            KIND_WRITE: begin
              mem_we    = in_square;
              mem_waddr = in_addr;
              mem_wdata = in_i.pixel_in;
            end
            KIND_READ: begin
              addr_d  = in_addr;
              zero_d  = !in_square;
              state_d = ST_RD_WAIT;
            end
            KIND_XFORM: begin
              walk_ctrl.start = 1'b1;
              state_d         = ST_X_RD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD_WAIT: begin
        // hold the address so the read data stays put while out_o is full
        raddr_a = addr_q;
        if (!out_valid_q || out_o.ready) begin
          pixel_d     = zero_q ? '0 : rdata_a;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_X_RD: begin
        state_d = ST_X_WA;
      end
      ST_X_WA: begin
        mem_we    = 1'b1;
        mem_waddr = walk_addr_a;
        mem_wdata = rdata_b;
        tmp_d     = rdata_a;
        state_d   = ST_X_WB;
      end
      ST_X_WB: begin
        mem_we         = 1'b1;
        mem_waddr      = walk_addr_b;
        mem_wdata      = tmp_q;
        walk_ctrl.step = 1'b1;
        state_d        = walk_last ? ST_IDLE : ST_X_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    zero_q  <= zero_d;
    tmp_q   <= tmp_d;
    pixel_q <= pixel_d;
  end

  sirf_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (walk_addr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  sirf_walk #(
    .Size  (Size),
    .AddrW (AddrW)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (walk_ctrl),
    .addr_a_o (walk_addr_a),
    .addr_b_o (walk_addr_b),
    .last_o   (walk_last)
  );

  a_rd_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_WAIT) |-> !mem_we)
    else $error("store written while a read result is pending");

  a_rd_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_WAIT && out_valid_q && !out_o.ready) |=> (state_q == ST_RD_WAIT))
    else $error("read result left the wait state while the output was full");

  a_xform_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_X_WB && walk_last) |=> (state_q == ST_IDLE))
    else $error("transform did not end after its last pair");

  a_swap_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_X_WB) |-> (mem_waddr == $past(walk_addr_b) && $past(state_q) == ST_X_WA))
    else $error("second write of a swap went to a different pair");

endmodule

// ===== test/square_image_rotate_flip_tb.sv =====
module square_image_rotate_flip_tb;
  import sirf_pkg::*;

  localparam int Side       = 8;
  localparam int ItemTarget = 1250;
  localparam int TailItems  = 120;
  // one rotation plus the return to idle, with some slack
  localparam int SettleCycles = 3 * Side * (Side / 2) + 3 * Side * (Side - 1) / 2 + 16;
  localparam int LongHold     = 300;
  localparam int RunLimit     = 12_000_000;

  // kind 3 has no name in the package: the block ignores it
  localparam kind_t KindUnused = 2'd3;

  logic clk_i;
  logic rst_ni;

  sirf_in_if  in_if ();
  sirf_out_if out_if ();

  square_image_rotate_flip #(
    .Size(Side)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  pix_t image_model [Side*Side];
  pix_t expected_pixels [$];

  bit src_idle_on;
  bit snk_idle_on;
  int sink_hold_req;
  int errors;
  int n_writes, n_reads, n_xforms, n_unused, reads_checked;
  int items_sent;

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Image predictor
  // ---------------------------------------------------------------------------

  function automatic void swap_px(int a, int b);
    pix_t t;
    t             = image_model[a];
    image_model[a] = image_model[b];
    image_model[b] = t;
  endfunction

  function automatic void model_transpose();
    for (int r = 0; r < Side; r++)
      for (int c = r + 1; c < Side; c++)
        swap_px(r * Side + c, c * Side + r);
  endfunction

  function automatic void model_mirror_lr();
    for (int r = 0; r < Side; r++)
      for (int c = 0; c < Side / 2; c++)
        swap_px(r * Side + c, r * Side + (Side - 1 - c));
  endfunction

  function automatic void model_mirror_tb();
    for (int r = 0; r < Side / 2; r++)
      for (int c = 0; c < Side; c++)
        swap_px(r * Side + c, (Side - 1 - r) * Side + c);
  endfunction

  function automatic void predict_cmd(kind_t k, row_t r, col_t c, pix_t p, op_t o);
    int at;
    bit on_image;
    at       = int'(r) * Side + int'(c);
    on_image = (int'(r) < Side) && (int'(c) < Side);
    case (k)
      KIND_WRITE: begin
        if (on_image) image_model[at] = p;
        n_writes++;
      end
      KIND_READ: begin
        expected_pixels.push_back(on_image ? image_model[at] : pix_t'(0));
        n_reads++;
      end
      KIND_XFORM: begin
        n_xforms++;
        case (o)
          OP_ROT_CW: begin
            model_transpose();
            model_mirror_lr();
          end
          OP_ROT_CCW: begin
            model_mirror_lr();
            model_transpose();
          end
          OP_MIRROR_TB: model_mirror_tb();
          default:      model_mirror_lr();
        endcase
      end
      default: n_unused++;
    endcase
    if (k != KindUnused) items_sent++;
  endfunction

  // ---------------------------------------------------------------------------
  // Command sender, result receiver, checker
  // ---------------------------------------------------------------------------

  task automatic send_cmd(input kind_t k, input row_t r, input col_t c, input pix_t p,
                          input op_t o);
    int gap;
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.kind         <= k;
    in_if.row          <= r;
    in_if.col          <= c;
    in_if.pixel_in     <= p;
    in_if.transform_op <= o;
    do @(posedge clk_i); while (!in_if.ready);
    predict_cmd(k, r, c, p, o);
  endtask

  task automatic send_any();
    send_cmd(kind_t'($urandom), row_t'($urandom), col_t'($urandom), pix_t'($urandom),
             op_t'($urandom));
  endtask

  // drop valid and hold until every read has been answered
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_pixels.size() != 0);
  endtask

  initial begin : result_ready
    int n;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (sink_hold_req > 0) begin
        n             = sink_hold_req;
        sink_hold_req = 0;
        out_if.ready <= 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
        n             = $urandom_range(1, 8);
        out_if.ready <= 1'b0;
      end else begin
        n             = 1;
        out_if.ready <= 1'b1;
      end
      repeat (n) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_pixels
    pix_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel_out: no read waiting, actual %02h", out_if.pixel_out);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        reads_checked++;
        if (out_if.pixel_out !== want) begin
          $error("pixel_out: expected %02h, actual %02h", want, out_if.pixel_out);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_reset_and_corners();
    send_cmd(KIND_READ, '0, '0, pix_t'($urandom), op_t'($urandom));
    send_cmd(KIND_READ, row_t'(Side - 1), col_t'(Side - 1), pix_t'($urandom),
             op_t'($urandom));
    send_cmd(KIND_WRITE, '0, '0, 8'hFF, op_t'($urandom));
    send_cmd(KIND_WRITE, '0, col_t'(Side - 1), 8'h01, op_t'($urandom));
    send_cmd(KIND_WRITE, row_t'(Side - 1), '0, 8'h80, op_t'($urandom));
    send_cmd(KIND_WRITE, row_t'(Side - 1), col_t'(Side - 1), 8'h7E, op_t'($urandom));
    send_cmd(KIND_READ, '0, '0, 8'h00, OP_MIRROR_LR);
    send_cmd(KIND_READ, '0, col_t'(Side - 1), 8'hFF, OP_ROT_CW);
    send_cmd(KIND_READ, row_t'(Side - 1), '0, 8'h55, OP_ROT_CCW);
    send_cmd(KIND_READ, row_t'(Side - 1), col_t'(Side - 1), 8'hAA, OP_MIRROR_TB);
  endtask

  task automatic test_each_transform();
    op_t ops [4];
    ops = '{OP_ROT_CW, OP_ROT_CCW, OP_MIRROR_TB, OP_MIRROR_LR};
    foreach (ops[i]) begin
      send_cmd(KIND_XFORM, row_t'($urandom), col_t'($urandom), pix_t'($urandom), ops[i]);
      send_cmd(KIND_READ, '0, '0, pix_t'($urandom), op_t'($urandom));
      send_cmd(KIND_READ, '0, col_t'(Side - 1), pix_t'($urandom), op_t'($urandom));
    end
  endtask

  task automatic test_unused_kind();
    send_cmd(KindUnused, row_t'($urandom), col_t'($urandom), pix_t'($urandom),
             op_t'($urandom));
    send_cmd(KIND_READ, '0, '0, pix_t'($urandom), op_t'($urandom));
    wait_drained();
  endtask

  // hold the result port so the output register fills and reads back up
  task automatic test_backpressure();
    sink_hold_req = LongHold;
    for (int i = 0; i < 20; i++) begin
      case (i % 4)
        0:       send_cmd(KIND_READ, row_t'($urandom), col_t'($urandom), pix_t'($urandom),
                          op_t'($urandom));
        1:       send_cmd(KIND_WRITE, row_t'($urandom), col_t'($urandom), pix_t'($urandom),
                          op_t'($urandom));
        2:       send_cmd(KIND_XFORM, row_t'($urandom), col_t'($urandom), pix_t'($urandom),
                          op_t'($urandom));
        default: send_any();
      endcase
    end
    wait_drained();
  endtask

  // one round: fill some pixels, transform up to twice, read back, with a little noise
  task automatic run_round();
    bit whole;
    int n_wr, n_xf, n_rd;
    whole = ($urandom_range(0, 11) == 0);
    n_wr  = whole ? Side * Side : $urandom_range(1, 12);
    for (int i = 0; i < n_wr; i++) begin
      if ($urandom_range(0, 15) == 0) send_any();
      if (whole)
        send_cmd(KIND_WRITE, row_t'(i / Side), col_t'(i % Side), pix_t'($urandom),
                 op_t'($urandom));
      else
        send_cmd(KIND_WRITE, row_t'($urandom), col_t'($urandom), pix_t'($urandom),
                 op_t'($urandom));
    end
    n_xf = $urandom_range(whole ? 1 : 0, 2);
    repeat (n_xf)
      send_cmd(KIND_XFORM, row_t'($urandom), col_t'($urandom), pix_t'($urandom),
               op_t'($urandom));
    n_rd = whole ? Side * Side : $urandom_range(1, 12);
    for (int i = 0; i < n_rd; i++) begin
      if ($urandom_range(0, 15) == 0) send_any();
      if (whole)
        send_cmd(KIND_READ, row_t'(i / Side), col_t'(i % Side), pix_t'($urandom),
                 op_t'($urandom));
      else
        send_cmd(KIND_READ, row_t'($urandom), col_t'($urandom), pix_t'($urandom),
                 op_t'($urandom));
    end
    if (src_idle_on && $urandom_range(0, 7) == 0) wait_drained();
  endtask

  task automatic test_random_rounds();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    while (items_sent < ItemTarget - TailItems) run_round();
  endtask

  task automatic test_quiet_tail();
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    while (items_sent < ItemTarget) run_round();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    foreach (image_model[i]) image_model[i] = '0;
    src_idle_on   = 1'b0;
    snk_idle_on   = 1'b0;
    sink_hold_req = 0;
    errors        = 0;
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.kind         <= KIND_WRITE;
    in_if.row          <= '0;
    in_if.col          <= '0;
    in_if.pixel_in     <= '0;
    in_if.transform_op <= OP_ROT_CW;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_and_corners();
    test_each_transform();
    test_unused_kind();
    test_backpressure();
    test_random_rounds();
    test_quiet_tail();

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d commands: %0d writes, %0d reads, %0d transforms, %0d ignored.",
             items_sent + n_unused, n_writes, n_reads, n_xforms, n_unused);
    $display("Checked %0d read beats under random stalls and a long output hold.",
             reads_checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(RunLimit);
    $display("Run timed out with %0d reads outstanding.", expected_pixels.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sirf_pkg.sv
rtl/sirf_in_if.sv
rtl/sirf_out_if.sv
rtl/sirf_store.sv
rtl/sirf_walk.sv
rtl/square_image_rotate_flip.sv
test/square_image_rotate_flip_tb.sv
